@@ rtl/plt_pkg.sv @@
// ============================================================================
// plt_pkg: shared types and constants for the positional list table
// Item layouts, request and status codes, and the structs passed between
// the controller and the row of storage cells.
// ============================================================================
package plt_pkg;

  // Number of entries the list can hold.
  localparam int CAPACITY = 128;
  // Bits needed to address one cell, and to hold a count of 0..CAPACITY.
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Request kinds.
  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_DELETE = 3'd1;
  localparam logic [2:0] KIND_GET    = 3'd2;
  localparam logic [2:0] KIND_LOCATE = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One request item.
  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [7:0]         found_position;
    logic [7:0]         list_length;
  } out_item_t;

  // Broadcast control from the controller to every cell.
  typedef struct packed {
    logic        ins;     // shift up and write at mpos
    logic        del;     // shift down from mpos
    idx_t        mpos;    // 0-based position for insert or delete
    logic [31:0] mval;    // value written by insert
    logic        is_get;  // search wave looks for spos, else for sval
    idx_t        spos;    // 0-based position for get
    cnt_t        cnt;     // current list length
    logic [31:0] sval;    // value searched by locate
  } cell_ctl_t;

  // Search wave handed from cell to cell.
  typedef struct packed {
    logic        vld;
    logic        fnd;
    logic [31:0] data;
    idx_t        idx;
  } wave_t;

endpackage

@@ rtl/plt_cell.sv @@
// ============================================================================
// plt_cell: one storage cell of the positional list table
// Holds one list entry, shifts with its neighbors on insert and delete, and
// passes the search wave on to the next cell, one cell per cycle.
// ============================================================================
module plt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  plt_pkg::idx_t       idx,
  input  plt_pkg::cell_ctl_t  ctl,
  input  logic [31:0]         left_data,
  input  logic [31:0]         right_data,
  output logic [31:0]         data_out,
  input  plt_pkg::wave_t      wave_in,
  output plt_pkg::wave_t      wave_out
);

  logic [31:0]    data_r;
  logic [31:0]    data_nxt;
  plt_pkg::wave_t wave_r;
  plt_pkg::wave_t wave_nxt;
  logic           hit;

  // Insert opens a gap at mpos; delete closes the gap at mpos.
  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (idx > ctl.mpos) begin
        data_nxt = left_data;
      end else if (idx == ctl.mpos) begin
        data_nxt = ctl.mval;
      end
    end else if (ctl.del) begin
      if (idx >= ctl.mpos) begin
        data_nxt = right_data;
      end
    end
  end

  // This cell matches a get by its position, a locate by its contents.
  always_comb begin
    if (ctl.is_get) begin
      hit = (idx == ctl.spos);
    end else begin
      hit = (plt_pkg::cnt_t'(idx) < ctl.cnt) && (data_r == ctl.sval);
    end
  end

  // The first hit along the chain is kept; later cells only forward it.
  always_comb begin
    wave_nxt.vld  = wave_in.vld;
    wave_nxt.fnd  = wave_in.fnd | hit;
    wave_nxt.data = wave_in.fnd ? wave_in.data : data_r;
    wave_nxt.idx  = wave_in.fnd ? wave_in.idx : idx;
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Wave register; only the valid flag is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r.vld <= 1'b0;
    end else begin
      wave_r.vld <= wave_nxt.vld;
    end
    wave_r.fnd  <= wave_nxt.fnd;
    wave_r.data <= wave_nxt.data;
    wave_r.idx  <= wave_nxt.idx;
  end

  assign data_out = data_r;
  assign wave_out = wave_r;

endmodule

@@ rtl/plt_ctrl.sv @@
// ============================================================================
// plt_ctrl: request controller of the positional list table
// Checks positions, keeps the list length, drives the cell controls, starts
// the search wave and holds the result item until it is taken.
// ============================================================================
module plt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  plt_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output plt_pkg::out_item_t  out_item,
  output plt_pkg::cell_ctl_t  ctl,
  output logic                start,
  input  plt_pkg::wave_t      wave_last
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  plt_pkg::cnt_t      count_r, count_nxt;
  logic               start_r, start_nxt;
  logic               sget_r, sget_nxt;
  plt_pkg::idx_t      spos_r, spos_nxt;
  logic [31:0]        sval_r, sval_nxt;
  logic               out_valid_r, out_valid_nxt;
  plt_pkg::out_item_t out_item_r, out_item_nxt;

  logic               accept;
  logic [15:0]        pos_w;
  logic [15:0]        cnt_w;
  logic               ins_pos_ok;
  logic               rd_pos_ok;
  logic               full;
  logic               do_ins;
  logic               do_del;
  plt_pkg::idx_t      req_idx;
  plt_pkg::cnt_t      found_cnt;

  // Accept only when idle and the output register is free or emptying.
  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // Position checks against the current length.
  assign pos_w      = 16'(in_item.position);
  assign cnt_w      = 16'(count_r);
  assign ins_pos_ok = (in_item.position != 8'd0) && (pos_w <= cnt_w + 16'd1);
  assign rd_pos_ok  = (in_item.position != 8'd0) && (pos_w <= cnt_w);
  assign full       = (count_r == plt_pkg::cnt_t'(plt_pkg::CAPACITY));
  assign req_idx    = plt_pkg::idx_t'(in_item.position - 8'd1);
  assign found_cnt  = plt_pkg::cnt_t'(wave_last.idx) + plt_pkg::cnt_t'(1);

  // Request decode, result formation and sequencing.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    start_nxt     = 1'b0;
    sget_nxt      = sget_r;
    spos_nxt      = spos_r;
    sval_nxt      = sval_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    do_ins        = 1'b0;
    do_del        = 1'b0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_item_nxt.status         = plt_pkg::ST_OK;
          out_item_nxt.read_value     = '0;
          out_item_nxt.found_position = '0;
          out_valid_nxt               = 1'b1;
          unique case (in_item.kind)
            plt_pkg::KIND_INSERT: begin
              if (!ins_pos_ok) begin
                out_item_nxt.status = plt_pkg::ST_RANGE;
              end else if (full) begin
                out_item_nxt.status = plt_pkg::ST_FULL;
              end else begin
                do_ins    = 1'b1;
                count_nxt = count_r + plt_pkg::cnt_t'(1);
              end
            end
            plt_pkg::KIND_DELETE: begin
              if (!rd_pos_ok) begin
                out_item_nxt.status = plt_pkg::ST_RANGE;
              end else begin
                do_del    = 1'b1;
                count_nxt = count_r - plt_pkg::cnt_t'(1);
              end
            end
            plt_pkg::KIND_GET: begin
              if (!rd_pos_ok) begin
                out_item_nxt.status = plt_pkg::ST_RANGE;
              end else begin
                out_valid_nxt = 1'b0;
                start_nxt     = 1'b1;
                sget_nxt      = 1'b1;
                spos_nxt      = req_idx;
                state_nxt     = S_SCAN;
              end
            end
            plt_pkg::KIND_LOCATE: begin
              out_valid_nxt = 1'b0;
              start_nxt     = 1'b1;
              sget_nxt      = 1'b0;
              sval_nxt      = in_item.value;
              state_nxt     = S_SCAN;
            end
            plt_pkg::KIND_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
          out_item_nxt.list_length = 8'(count_nxt);
        end
      end
      S_SCAN: begin
        // The wave leaving the last cell carries the answer.
        if (wave_last.vld) begin
          out_valid_nxt               = 1'b1;
          out_item_nxt.status         = plt_pkg::ST_OK;
          out_item_nxt.list_length    = 8'(count_r);
          if (sget_r) begin
            out_item_nxt.read_value     = wave_last.data;
            out_item_nxt.found_position = '0;
          end else begin
            out_item_nxt.read_value     = '0;
            out_item_nxt.found_position = wave_last.fnd ? 8'(found_cnt) : 8'd0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Search request and result payload registers.
  always_ff @(posedge clk) begin
    sget_r     <= sget_nxt;
    spos_r     <= spos_nxt;
    sval_r     <= sval_nxt;
    out_item_r <= out_item_nxt;
  end

  // Broadcast to the cells: shifts act on the accepted item, searches on
  // the latched request.
  always_comb begin
    ctl.ins    = do_ins;
    ctl.del    = do_del;
    ctl.mpos   = req_idx;
    ctl.mval   = in_item.value;
    ctl.is_get = sget_r;
    ctl.spos   = spos_r;
    ctl.cnt    = count_r;
    ctl.sval   = sval_r;
  end

  assign start     = start_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/positional_list_table_core.sv @@
// ============================================================================
// positional_list_table_core: bounded ordered list in a row of cells
// Insert, delete, get, locate and clear on a list of signed words, kept in
// a chain of cells that shift together and pass a search wave along.
// ============================================================================
//
//   Channel  Ports                          Direction  Contents
//   -------  -----------------------------  ---------  --------------------------
//   request  in_valid, in_stall, in_item    in         kind, position, value
//   result   out_valid, out_stall, out_item out        status, read_value,
//                                                      found_position, list_length
//
// For insert, delete, clear, unused kinds and rejected requests, the cells
// shift in the cycle of acceptance and the result is registered.
// A valid get or a locate is answered by the search wave that walks the
// cell chain one cell per cycle; one item is in work at a time.
// Reset empties the list at once; cell contents are not cleared.
// A held result stalls new requests only while out_stall keeps it waiting.
//
module positional_list_table_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  plt_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output plt_pkg::out_item_t  out_item
);

  plt_pkg::cell_ctl_t ctl;
  logic               start;
  logic [31:0]        data_w [plt_pkg::CAPACITY];
  plt_pkg::wave_t     wave_w [plt_pkg::CAPACITY + 1];

  // Request controller.
  plt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .ctl       (ctl),
    .start     (start),
    .wave_last (wave_w[plt_pkg::CAPACITY])
  );

  // The wave enters the first cell empty: vld, fnd, data, idx.
  assign wave_w[0] = {start, 1'b0, 32'd0, plt_pkg::idx_t'(0)};

  // Row of cells, each linked to both neighbors.
  for (genvar i = 0; i < plt_pkg::CAPACITY; i++) begin : g_cell
    logic [31:0] left_d;
    logic [31:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = data_w[i-1];
    end

    if (i == plt_pkg::CAPACITY - 1) begin : g_last
      assign right_d = data_w[i];
    end else begin : g_mid_r
      assign right_d = data_w[i+1];
    end

    plt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .idx        (plt_pkg::idx_t'(i)),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .data_out   (data_w[i]),
      .wave_in    (wave_w[i]),
      .wave_out   (wave_w[i+1])
    );
  end

endmodule

@@ verif/positional_list_table_core_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// positional_list_table_core_test: self-checking bench for the list table
// Drives insert, delete, get, locate, clear and unused request kinds through
// the valid/stall request channel, keeps its own copy of the list to predict
// every result item, and compares each accepted result field by field. Both
// channels idle at random, with one long stretch of back-to-back traffic.
// ============================================================================
module positional_list_table_core_test;
  import plt_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 790;
  // Request kinds the block must ignore.
  localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [2:0] KIND_UNUSED_MID = 3'd6;
  localparam logic [2:0] KIND_UNUSED_HI = 3'd7;
  // Values that repeat often, so locate sees duplicates and sign extremes.
  localparam logic [31:0] VALUE_POOL [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                             32'h7FFF_FFFF, 32'h8000_0000};

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;

  // Predicted list contents, position 1 at index 0.
  logic signed [31:0] list_entries[$];
  out_item_t          pending_results[$];
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  bit                 steady_traffic = 1'b0;

  positional_list_table_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("positional_list_table_core: mismatch");
      $finish;
    end
  end

  // The result side stalls at random except during the steady stretch.
  always @(posedge clk) begin
    out_stall <= !steady_traffic && ($urandom_range(99) < 32);
  end

  // Applies one request to the predicted list and returns its result item.
  function automatic out_item_t predict_list_op(input in_item_t req);
    out_item_t   res;
    int unsigned pos;
    res = '0;
    pos = req.position;
    case (req.kind)
      KIND_INSERT: begin
        if (pos < 1 || pos > list_entries.size() + 1) begin
          res.status = ST_RANGE;
        end else if (list_entries.size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          list_entries.insert(pos - 1, req.value);
        end
      end
      KIND_DELETE: begin
        if (pos < 1 || pos > list_entries.size()) begin
          res.status = ST_RANGE;
        end else begin
          list_entries.delete(pos - 1);
        end
      end
      KIND_GET: begin
        if (pos < 1 || pos > list_entries.size()) begin
          res.status = ST_RANGE;
        end else begin
          res.read_value = list_entries[pos - 1];
        end
      end
      KIND_LOCATE: begin
        for (int j = 0; j < list_entries.size(); j++) begin
          if (list_entries[j] == req.value) begin
            res.found_position = 8'(j + 1);
            break;
          end
        end
      end
      KIND_CLEAR: begin
        list_entries.delete();
      end
      default: begin
      end
    endcase
    res.list_length = 8'(list_entries.size());
    return res;
  endfunction

  // Presents one request, waits for it to be taken, then records the
  // expected result. Stall is sampled at the falling edge, where it is
  // stable until the next rising edge.
  task automatic send_request(input logic [2:0] kind, input logic [7:0] position,
                              input logic [31:0] value);
    in_item_t req;
    bit       taken;
    req.kind = kind;
    req.position = position;
    req.value = value;
    while (!steady_traffic && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    pending_results.push_back(predict_list_op(req));
  endtask

  // Compare each accepted result item with the oldest prediction.
  always @(negedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result item with none expected: %p", out_item);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          mismatch_count++;
        end
        if (out_item.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value,
                 out_item.read_value);
          mismatch_count++;
        end
        if (out_item.found_position !== want.found_position) begin
          $error("found_position: expected %0d, got %0d", want.found_position,
                 out_item.found_position);
          mismatch_count++;
        end
        if (out_item.list_length !== want.list_length) begin
          $error("list_length: expected %0d, got %0d", want.list_length,
                 out_item.list_length);
          mismatch_count++;
        end
      end
    end
  end

  // Every access on an empty list, and inserts at bad positions.
  task automatic test_empty_list();
    send_request(KIND_GET, 8'd1, 32'h0);
    send_request(KIND_DELETE, 8'd1, 32'h0);
    send_request(KIND_LOCATE, 8'd0, 32'h0);
    send_request(KIND_INSERT, 8'd0, 32'h1234_5678);
    send_request(KIND_INSERT, 8'd2, 32'h1234_5678);
  endtask

  // Appends, front and middle inserts, reads at both ends and past them,
  // locate hits and misses, and deletes in and out of range.
  task automatic test_edit_and_search();
    send_request(KIND_INSERT, 8'd1, 32'h7FFF_FFFF);
    send_request(KIND_INSERT, 8'd2, 32'h8000_0000);
    send_request(KIND_INSERT, 8'd1, 32'hFFFF_FFFF);
    send_request(KIND_INSERT, 8'd2, 32'd5);
    send_request(KIND_GET, 8'd1, 32'h0);
    send_request(KIND_GET, 8'd4, 32'h0);
    send_request(KIND_GET, 8'd5, 32'h0);
    send_request(KIND_GET, 8'd0, 32'h0);
    send_request(KIND_GET, 8'd255, 32'h0);
    send_request(KIND_LOCATE, 8'd0, 32'h8000_0000);
    send_request(KIND_LOCATE, 8'd0, 32'd12345);
    send_request(KIND_DELETE, 8'd0, 32'h0);
    send_request(KIND_DELETE, 8'd255, 32'h0);
    send_request(KIND_DELETE, 8'd2, 32'h0);
    send_request(KIND_INSERT, 8'd255, 32'hFFFF_FFFF);
  endtask

  // Unused kinds carry all-ones fields and must change nothing.
  task automatic test_unused_kinds();
    send_request(KIND_UNUSED_LO, 8'd255, 32'hFFFF_FFFF);
    send_request(KIND_UNUSED_MID, 8'd255, 32'hFFFF_FFFF);
    send_request(KIND_UNUSED_HI, 8'd255, 32'hFFFF_FFFF);
  endtask

  // Clear, then confirm the list reads as empty.
  task automatic test_clear();
    send_request(KIND_CLEAR, 8'd0, 32'h0);
    send_request(KIND_GET, 8'd1, 32'h0);
  endtask

  // Fill to capacity with scattered inserts, then probe the full list.
  task automatic test_full_list();
    send_request(KIND_CLEAR, 8'd0, 32'h0);
    while (list_entries.size() < CAPACITY) begin
      send_request(KIND_INSERT, 8'($urandom_range(list_entries.size() + 1, 1)),
                   $urandom());
    end
    send_request(KIND_INSERT, 8'd1, $urandom());
    send_request(KIND_INSERT, 8'(CAPACITY + 1), $urandom());
    send_request(KIND_INSERT, 8'(CAPACITY + 2), $urandom());
    send_request(KIND_INSERT, 8'd0, $urandom());
    send_request(KIND_INSERT, 8'd255, $urandom());
    send_request(KIND_GET, 8'(CAPACITY), 32'h0);
    send_request(KIND_LOCATE, 8'd0, list_entries[CAPACITY - 1]);
    send_request(KIND_DELETE, 8'(CAPACITY), 32'h0);
    send_request(KIND_GET, 8'(CAPACITY), 32'h0);
    send_request(KIND_DELETE, 8'd1, 32'h0);
  endtask

  // Mixed traffic whose fill target moves between nearly empty and full.
  task automatic test_random_traffic();
    int unsigned fill_goal;
    int unsigned roll;
    int unsigned size;
    int unsigned pos;
    logic [2:0]  kind;
    logic [31:0] val;
    fill_goal = CAPACITY / 2;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_traffic = (n >= 300 && n < 450);
      if (n % 100 == 0) begin
        case ($urandom_range(2))
          0: fill_goal = 2;
          1: fill_goal = CAPACITY / 2;
          default: fill_goal = CAPACITY;
        endcase
      end
      size = list_entries.size();
      roll = $urandom_range(99);
      if (roll < ((size < fill_goal) ? 45 : 20)) begin
        kind = KIND_INSERT;
      end else if (roll < 60) begin
        kind = KIND_DELETE;
      end else if (roll < 78) begin
        kind = KIND_GET;
      end else if (roll < 97) begin
        kind = KIND_LOCATE;
      end else if (roll == 97) begin
        kind = KIND_CLEAR;
      end else begin
        kind = 3'($urandom_range(KIND_UNUSED_HI, KIND_UNUSED_LO));
      end
      // Positions are mostly in range; some land anywhere.
      if (kind == KIND_INSERT) begin
        pos = $urandom_range(size + 1, 1);
      end else begin
        pos = (size > 0) ? $urandom_range(size, 1) : 1;
      end
      if ($urandom_range(9) == 0) begin
        pos = $urandom_range(255);
      end
      // Values: pooled for duplicates, held entries for locate hits, or random.
      if (kind == KIND_LOCATE && size > 0 && $urandom_range(9) < 6) begin
        val = list_entries[$urandom_range(size - 1)];
      end else if ($urandom_range(9) < 4) begin
        val = VALUE_POOL[$urandom_range(3)];
      end else begin
        val = $urandom();
      end
      send_request(kind, 8'(pos), val);
    end
    steady_traffic = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_edit_and_search();
    test_unused_kinds();
    test_clear();
    test_full_list();
    test_random_traffic();
    in_valid <= 1'b0;
    // Drain, then allow a full search time for any stray result.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("positional_list_table_core: match");
    end else begin
      $display("positional_list_table_core: mismatch");
    end
    $finish;
  end

endmodule

@@ positional_list_table_core.f @@
rtl/plt_pkg.sv
rtl/plt_cell.sv
rtl/plt_ctrl.sv
rtl/positional_list_table_core.sv
verif/positional_list_table_core_test.sv
